>>> src/mfsgd_pkg.sv
package mfsgd_pkg;

	localparam int MAX_USERS = 1024;
	localparam int MAX_ITEMS = 1024;
	localparam int MAX_DIMS  = 32;

	localparam int USER_W = $clog2(MAX_USERS);
	localparam int ITEM_W = $clog2(MAX_ITEMS);
	localparam int DIM_W  = $clog2(MAX_DIMS);
	localparam int CNT_W  = DIM_W + 1;

	localparam logic [2:0] OP_WR_USER = 3'd0;
	localparam logic [2:0] OP_WR_ITEM = 3'd1;
	localparam logic [2:0] OP_RD_USER = 3'd2;
	localparam logic [2:0] OP_RD_ITEM = 3'd3;
	localparam logic [2:0] OP_TRAIN   = 3'd4;
	localparam logic [2:0] OP_PREDICT = 3'd5;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_SKIP = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	localparam logic [1:0] CFG_LR   = 2'd0;
	localparam logic [1:0] CFG_REG  = 2'd1;
	localparam logic [1:0] CFG_DIMS = 2'd2;

	localparam logic signed [55:0] S32_MAX = 56'sd2147483647;
	localparam logic signed [55:0] S32_MIN = -56'sd2147483648;

	// Returns the overflow flag above the saturated 32-bit value.
	function automatic logic [32:0] sat32(input logic signed [55:0] x);
		logic [32:0] r;
		if (x > S32_MAX) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (x < S32_MIN) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, x[31:0]};
		end
		return r;
	endfunction

endpackage

>>> src/mf_sgd_factor_engine.sv
// Matrix factorization SGD engine with 1024 user rows and 1024 item rows of 32 signed Q16.16
// factors each, held in two single-port memories with registered reads. All products go
// through one shared 35x35 multiplier under a sequencer, and one item is taken at a time.
// Predict streams the dot product over the D dimensions in use, one dimension per cycle
// through the memory and multiplier. Train runs the same dot product and then updates
// each user and item factor, and each update needs four passes through the multiplier.
// A finished result waits in an output register until transferred, and no new item is
// taken while it waits.
module mf_sgd_factor_engine
	import mfsgd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// opcode[2:0], user_index[12:3], item_index[22:13], dim_index[27:23], value[59:28]
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// result_value[31:0], status[33:32]
	output logic [39:0] m_tdata
);

	typedef enum logic [3:0] {
		IDLE, WR, RDA, RDB, DOT, UPD_RD, UPD_LD, UPD_A, UPD_B, UPD_C, UPD_D, UPD_E, UPD_F, FIN
	} state_t;

	state_t state_q;

	logic [15:0] lr_q, rw_q;
	logic [5:0]  dims_q;

	logic [2:0]        op_q;
	logic [USER_W-1:0] u_q;
	logic [ITEM_W-1:0] i_q;
	logic [DIM_W-1:0]  d_q;
	logic [31:0]       v_q;
	logic [CNT_W-1:0]  k_q, n_q;
	logic              v1_q, v2_q, phase_q, sat_q;
	logic signed [52:0] acc_q;
	logic signed [31:0] err_q, x_q, y_q;
	logic signed [47:0] a_q;
	logic signed [49:0] g_q;
	logic signed [51:0] wgh_q;
	logic signed [69:0] prod_q;
	logic [31:0] res_q;
	logic [1:0]  stat_q;
	logic        out_v_q;

	logic [31:0] umem [MAX_USERS*MAX_DIMS];
	logic [31:0] imem [MAX_ITEMS*MAX_DIMS];
	logic [31:0] urd_q, ird_q;

	logic [DIM_W-1:0] col;
	logic [USER_W+DIM_W-1:0] u_addr;
	logic [ITEM_W+DIM_W-1:0] i_addr;
	logic u_we, i_we;
	logic [31:0] u_wd, i_wd;
	logic signed [34:0] mul_a, mul_b;
	logic [32:0] err_s, dot_s, new_s;
	logic signed [52:0] step;
	logic [CNT_W-1:0] n_in;
	logic in_acc;

	assign in_acc = s_tvalid && s_tready;
	assign s_tready = (state_q == IDLE) && !out_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata = {6'd0, stat_q, res_q};

	assign n_in = (dims_q == 6'd0) ? CNT_W'(1) :
		(dims_q > 6'(MAX_DIMS)) ? CNT_W'(MAX_DIMS) : CNT_W'(dims_q);

	assign col = (state_q == WR || state_q == RDA) ? d_q : k_q[DIM_W-1:0];
	assign u_addr = {u_q, col};
	assign i_addr = {i_q, col};

	assign step = 53'(wgh_q) + 53'({1'b0, prod_q[31:16]});
	assign new_s = sat32(56'(x_q) + 56'(step));
	assign err_s = sat32(56'($signed(v_q)) - 56'(acc_q));
	assign dot_s = sat32(56'(acc_q));

	assign u_we = (state_q == WR && op_q == OP_WR_USER) || (state_q == UPD_F && !phase_q);
	assign i_we = (state_q == WR && op_q == OP_WR_ITEM) || (state_q == UPD_F && phase_q);
	assign u_wd = (state_q == WR) ? v_q : new_s[31:0];
	assign i_wd = (state_q == WR) ? v_q : new_s[31:0];

	always_ff @(posedge clk) begin
		if (u_we) begin
			umem[u_addr] <= u_wd;
		end
		urd_q <= umem[u_addr];
	end

	always_ff @(posedge clk) begin
		if (i_we) begin
			imem[i_addr] <= i_wd;
		end
		ird_q <= imem[i_addr];
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			DOT: begin
				mul_a = 35'($signed(urd_q));
				mul_b = 35'($signed(ird_q));
			end
			UPD_A: begin
				mul_a = 35'(err_q);
				mul_b = 35'(y_q);
			end
			UPD_B: begin
				mul_a = $signed({19'd0, rw_q});
				mul_b = 35'(x_q);
			end
			UPD_D: begin
				mul_a = $signed({19'd0, lr_q});
				mul_b = 35'($signed(g_q[49:16]));
			end
			UPD_E: begin
				mul_a = $signed({19'd0, lr_q});
				mul_b = $signed({19'd0, g_q[15:0]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q   <= 16'd655;
			rw_q   <= 16'd655;
			dims_q <= 6'd32;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_LR:   lr_q   <= cfg_data;
				CFG_REG:  rw_q   <= cfg_data;
				CFG_DIMS: dims_q <= cfg_data[5:0];
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			out_v_q <= 1'b0;
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
			phase_q <= 1'b0;
			sat_q   <= 1'b0;
			k_q     <= '0;
			n_q     <= '0;
			acc_q   <= '0;
		end else begin
			if (out_v_q && m_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_acc) begin
						op_q    <= s_tdata[2:0];
						u_q     <= s_tdata[12:3];
						i_q     <= s_tdata[22:13];
						d_q     <= s_tdata[27:23];
						v_q     <= s_tdata[59:28];
						n_q     <= n_in;
						k_q     <= '0;
						acc_q   <= '0;
						sat_q   <= 1'b0;
						v1_q    <= 1'b0;
						v2_q    <= 1'b0;
						phase_q <= 1'b0;
						res_q   <= '0;
						stat_q  <= (s_tdata[2:0] == OP_TRAIN && s_tdata[59:28] == 32'd0) ?
							ST_SKIP : ST_DONE;
						case (s_tdata[2:0])
							OP_WR_USER, OP_WR_ITEM: state_q <= WR;
							OP_RD_USER, OP_RD_ITEM: state_q <= RDA;
							OP_TRAIN: begin
								if (s_tdata[59:28] == 32'd0) begin
									state_q <= FIN;
								end else begin
									state_q <= DOT;
								end
							end
							OP_PREDICT: state_q <= DOT;
							default: state_q <= FIN;
						endcase
					end
				end
				WR: state_q <= FIN;
				RDA: state_q <= RDB;
				RDB: begin
					res_q   <= (op_q == OP_RD_USER) ? urd_q : ird_q;
					state_q <= FIN;
				end
				DOT: begin
					v1_q <= (k_q < n_q);
					v2_q <= v1_q;
					if (k_q < n_q) begin
						k_q <= k_q + CNT_W'(1);
					end
					if (v2_q) begin
						acc_q <= acc_q + 53'($signed(prod_q[63:16]));
					end
					if (k_q == n_q && !v1_q && !v2_q) begin
						k_q <= '0;
						if (op_q == OP_PREDICT) begin
							res_q  <= dot_s[31:0];
							stat_q <= dot_s[32] ? ST_SAT : ST_DONE;
							state_q <= FIN;
						end else begin
							err_q   <= $signed(err_s[31:0]);
							sat_q   <= err_s[32];
							state_q <= UPD_RD;
						end
					end
				end
				UPD_RD: state_q <= UPD_LD;
				UPD_LD: begin
					x_q     <= $signed(urd_q);
					y_q     <= $signed(ird_q);
					phase_q <= 1'b0;
					state_q <= UPD_A;
				end
				UPD_A: state_q <= UPD_B;
				UPD_B: begin
					a_q     <= prod_q[63:16];
					state_q <= UPD_C;
				end
				UPD_C: begin
					g_q     <= 50'(a_q) * 50'sd2 - 50'($signed(prod_q[63:16]));
					state_q <= UPD_D;
				end
				UPD_D: state_q <= UPD_E;
				UPD_E: begin
					wgh_q   <= prod_q[51:0];
					state_q <= UPD_F;
				end
				UPD_F: begin
					sat_q <= sat_q | new_s[32];
					if (!phase_q) begin
						x_q     <= y_q;
						y_q     <= $signed(new_s[31:0]);
						phase_q <= 1'b1;
						state_q <= UPD_A;
					end else begin
						phase_q <= 1'b0;
						if (k_q + CNT_W'(1) == n_q) begin
							res_q   <= err_q;
							stat_q  <= (sat_q | new_s[32]) ? ST_SAT : ST_DONE;
							state_q <= FIN;
						end else begin
							k_q     <= k_q + CNT_W'(1);
							state_q <= UPD_RD;
						end
					end
				end
				FIN: begin
					out_v_q <= 1'b1;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	a_one_store_written: assert property (@(posedge clk) disable iff (!arst_n)
		!(u_we && i_we)) else $error("both factor stores written in one cycle");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != IDLE) else $error("accepted item did not start");

	a_update_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == UPD_F |-> k_q < n_q) else $error("update beyond dimension count");

	a_dot_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == DOT |-> k_q <= n_q) else $error("dot product count overran");

endmodule
